// ===== design/wnm_pkg.sv =====
// ----------------------------------------------------------------------------
// wnm_pkg - shared definitions of the wildcard name matcher
// Character codes, register indexes, widths and the types that pass
// between the matcher cells and the top level.
// ----------------------------------------------------------------------------
package wnm_pkg;

    // Pattern and name character widths
    localparam int CHAR_W        = 8;
    localparam int LEN_W         = 6;
    localparam int WORD_W        = 64;
    localparam int CHARS_PER_WORD = WORD_W / CHAR_W;
    localparam int CFG_IDX_W     = 3;
    localparam int MAX_CHARS     = 32;

    // Default number of pattern positions
    localparam int PATTERN_CHARS_DEF = 32;

    // Special pattern bytes
    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;
    localparam logic [CHAR_W-1:0] END_CHAR  = 8'h00;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORD_0 = 3'd0,
        CFG_WORD_1 = 3'd1,
        CFG_WORD_2 = 3'd2,
        CFG_WORD_3 = 3'd3,
        CFG_LENGTH = 3'd4
    } cfg_idx_t;

    // Signals handed from one cell to the next
    typedef struct packed {
        logic in_use;   // this position lies inside the pattern in effect
        logic advance;  // position reached by consuming the current byte
        logic closure;  // star closure carried from the left
        logic start;    // start set (bit 0 plus leading stars)
    } link_t;

    // Per-beat control broadcast to every cell
    typedef struct packed {
        logic              fresh;    // active set is the start set
        logic              step;     // commit the new active set
        logic [CHAR_W-1:0] name_chr; // name byte of the current beat
    } step_t;

endpackage

// ===== design/wildcard_name_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_name_matcher - streaming glob matcher for file names
// Matches a stream of name bytes against a configured glob pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Write the pattern through the cfg port: indexes 0..3 carry pattern bytes
//   0..31 (byte i in bits 8*(i%8) of word i/8), index 4 the pattern length.
//   '*' matches any run of bytes, '?' one byte, anything else itself. A
//   write to one of these indexes restarts the name in progress.
//   Name bytes arrive one per s_ beat, s_tlast marking the final byte. On
//   that beat one result is produced on the m_ side: m_tdata[0] = 1 when
//   the whole name matched. Other beats produce nothing.
//   Throughput is one byte per cycle while s_tready is high: the row of
//   position cells updates the active set, the star closure rippling along the row.
//   The result of the final beat is registered before it shows on m_tvalid.
//   A result register and a skid entry sit on the output: input beats keep
//   being taken while one result waits, s_tready drops only while two
//   results wait on a stalled receiver.
//   Reset clears the pattern to empty (nothing matches) and the outputs.
// ----------------------------------------------------------------------------
module wildcard_name_matcher #(
    parameter int PATTERN_CHARS = wnm_pkg::PATTERN_CHARS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [wnm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wnm_pkg::WORD_W-1:0]      cfg_data,
    // name byte stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] name_byte
    input  logic                            s_tlast,   // last_byte
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata    // [0] matched, [7:1] zero
);
    import wnm_pkg::*;

    logic [LEN_W-1:0] pat_len_reg;
    logic             fresh_reg;

    logic             restart;
    logic             accept;
    logic             space;
    logic             matched;
    logic             out_bit;
    logic             final_pos;
    logic [CHARS_PER_WORD*0+3:0] word_hit;
    step_t            ctrl;
    link_t            links [PATTERN_CHARS+1];
    logic [PATTERN_CHARS-1:0] match_vec;

    // Decode the register index of a write
    always_comb
    begin
        word_hit = '0;
        restart  = 1'b0;
        unique case (cfg_index)
            CFG_WORD_0: begin word_hit[0] = cfg_we; restart = cfg_we; end
            CFG_WORD_1: begin word_hit[1] = cfg_we; restart = cfg_we; end
            CFG_WORD_2: begin word_hit[2] = cfg_we; restart = cfg_we; end
            CFG_WORD_3: begin word_hit[3] = cfg_we; restart = cfg_we; end
            CFG_LENGTH: restart = cfg_we;
            default:    restart = 1'b0;
        endcase
    end

    // Hold the pattern length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg <= '0;
        end
        else if (cfg_we && cfg_index == CFG_LENGTH)
        begin
            pat_len_reg <= cfg_data[LEN_W-1:0];
        end
    end

    assign accept = s_tvalid && s_tready;

    // Restart after a write or a final beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= 1'b1;
        end
        else if (restart || (accept && s_tlast))
        begin
            fresh_reg <= 1'b1;
        end
        else if (accept)
        begin
            fresh_reg <= 1'b0;
        end
    end

    assign ctrl.fresh    = fresh_reg;
    assign ctrl.step     = accept && !s_tlast;
    assign ctrl.name_chr = s_tdata;

    // Seed the row: position 0 is always in the start set
    assign links[0].in_use  = 1'b1;
    assign links[0].advance = 1'b0;
    assign links[0].closure = 1'b0;
    assign links[0].start   = 1'b1;

    // Row of position cells
    for (genvar p = 0; p < PATTERN_CHARS; p++)
    begin : g_cell
        localparam int WORD_SEL = p / CHARS_PER_WORD;
        localparam int BYTE_SEL = p % CHARS_PER_WORD;

        wnm_cell #(
            .CELL_INDEX (p)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .pat_we     (word_hit[WORD_SEL]),
            .pat_wdata  (cfg_data[BYTE_SEL*CHAR_W +: CHAR_W]),
            .pat_len    (pat_len_reg),
            .ctrl       (ctrl),
            .link_in    (links[p]),
            .link_out   (links[p+1]),
            .match_here (match_vec[p])
        );
    end

    // Position just past the last cell, reached by a full-length pattern
    assign final_pos = links[PATTERN_CHARS].in_use
                       && (links[PATTERN_CHARS].advance || links[PATTERN_CHARS].closure);
    assign matched   = (|match_vec) || final_pos;

    wnm_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && s_tlast),
        .push_data (matched),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_bit)
    );

    assign s_tready = space;
    assign m_tdata  = {7'd0, out_bit};

endmodule

// ===== design/wnm_cell.sv =====
// ----------------------------------------------------------------------------
// wnm_cell - one pattern position of the matcher chain
// Holds one pattern byte and the active bit of its position, and passes
// advance, star closure and start set information to its right neighbour.
// ----------------------------------------------------------------------------
module wnm_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pat_we,
    input  logic [wnm_pkg::CHAR_W-1:0]    pat_wdata,
    input  logic [wnm_pkg::LEN_W-1:0]     pat_len,
    input  wnm_pkg::step_t                ctrl,
    input  wnm_pkg::link_t                link_in,
    output wnm_pkg::link_t                link_out,
    output logic                          match_here
);
    import wnm_pkg::*;

    logic [CHAR_W-1:0] pat_chr_reg;
    logic              active_reg;
    logic              active_next;

    logic in_use;
    logic is_star;
    logic is_any;
    logic active;
    logic stay;
    logic adv;

    // Hold the pattern byte of this position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_chr_reg <= END_CHAR;
        end
        else if (pat_we)
        begin
            pat_chr_reg <= pat_wdata;
        end
    end

    // Position is in use when inside the length and no end byte at or before it
    assign in_use  = link_in.in_use && (LEN_W'(CELL_INDEX) < pat_len)
                     && (pat_chr_reg != END_CHAR);
    assign is_star = (pat_chr_reg == STAR_CHAR);
    assign is_any  = (pat_chr_reg == ANY_CHAR);

    // Use the start set right after a restart
    assign active = ctrl.fresh ? link_in.start : active_reg;

    // A star keeps its position, any other byte moves one on when it fits
    assign stay = in_use && active && is_star;
    assign adv  = in_use && active && !is_star && (is_any || pat_chr_reg == ctrl.name_chr);

    assign active_next = stay || link_in.advance || link_in.closure;

    assign link_out.in_use  = in_use;
    assign link_out.advance = adv;
    assign link_out.closure = active_next && in_use && is_star;
    assign link_out.start   = link_in.start && in_use && is_star;

    // First position past the pattern reports the match
    assign match_here = active_next && link_in.in_use && !in_use;

    // Advance the active bit on every non-final beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            active_reg <= active_next;
        end
    end

endmodule

// ===== design/wnm_out_stage.sv =====
// ----------------------------------------------------------------------------
// wnm_out_stage - result register with skid entry
// Two-entry output buffer so that the input side keeps flowing while one
// result waits for the receiver.
// ----------------------------------------------------------------------------
module wnm_out_stage (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic push_data,
    output logic space,
    output logic out_valid,
    input  logic out_ready,
    output logic out_data
);
    import wnm_pkg::*;

    logic out_valid_reg;
    logic out_data_reg;
    logic skid_valid_reg;
    logic skid_data_reg;
    logic pop;

    assign pop   = out_valid_reg && out_ready;
    assign space = !skid_valid_reg;

    // Hold results, refill the output from the skid entry when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_data_reg   <= 1'b0;
            skid_data_reg  <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg  <= push_data;
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_data_reg  <= push_data;
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/wnm_checker.sv =====
// ----------------------------------------------------------------------------
// wnm_checker - port-level checks of the wildcard name matcher
// Watches the stream ports over time and flags ordering and buffering slips.
// ----------------------------------------------------------------------------
module wnm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import wnm_pkg::*;

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A new result only follows a final name beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without a final beat");

    // A non-final beat into an empty output gives no result
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
        else $error("result from a non-final beat");

    // Input stalls only while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind wildcard_name_matcher wnm_checker u_wnm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
